### design/arf_pkg.sv
// shared types, codes and constants for the adaptive rate audio fifo
`timescale 1ns / 1ps
`default_nettype none

package arf_pkg;

    localparam int CFG_DW    = 40;
    localparam int CFG_IW    = 3;
    localparam int PHASE_W   = 40;
    localparam int AVG_W     = 32;
    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 13;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_BLOCK = 2'd1;
    localparam logic [1:0] ACT_PULL  = 2'd2;

    localparam logic [CFG_IW-1:0] REG_BASE_INC  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_TARGET    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DEADBAND  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_GAIN      = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WEIGHT    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_BLOCK_LEN = 3'd5;

    localparam logic [39:0] RST_BASE_INC  = 40'd68719476736;
    localparam logic [12:0] RST_TARGET    = 13'd2205;
    localparam logic [12:0] RST_DEADBAND  = 13'd132;
    localparam logic [15:0] RST_GAIN      = 16'd35334;
    localparam logic [15:0] RST_WEIGHT    = 16'd655;
    localparam logic [12:0] RST_BLOCK_LEN = 13'd220;

    localparam logic [PHASE_W-1:0] PHASE_ONE = 40'h10_0000_0000;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_BLOCK,
        OP_PULL,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SAMPLE_W-1:0] sample;
    } q_item_t;

    typedef struct packed {
        logic [39:0] base_inc;
        logic [12:0] target;
        logic [12:0] deadband;
        logic [15:0] gain;
        logic [15:0] weight;
        logic [12:0] block_len;
    } cfg_t;

    typedef struct packed {
        logic               busy;
        logic [PHASE_W-1:0] increment;
    } rate_out_t;

    typedef enum logic [2:0] {
        RS_IDLE,
        RS_AVG_MUL,
        RS_AVG_FC,
        RS_AVG_SUM,
        RS_ERR,
        RS_TRIM,
        RS_INC
    } rate_state_t;

endpackage

`default_nettype wire

### design/arf_front.sv
// front part: accepts items, classifies the action and queues them
`timescale 1ns / 1ps
`default_nettype none

module arf_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          action,
    input  wire logic signed [15:0]  sample_in,
    input  wire logic                q_pop,
    output logic                     q_valid,
    output arf_pkg::q_item_t         q_item
);
    import arf_pkg::*;

    q_item_t    slot_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       wr_idx;
    q_item_t    new_item;

    always_comb
    begin
        new_item.sample = sample_in;
        case (action)
            ACT_PUSH:  new_item.op = OP_PUSH;
            ACT_BLOCK: new_item.op = OP_BLOCK;
            ACT_PULL:  new_item.op = OP_PULL;
            default:   new_item.op = OP_NONE;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[0];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, q_pop};
        wr_idx     = q_pop ? 1'b0 : count_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !wr_idx)
        begin
            slot_reg[0] <= new_item;
        end
        else if (q_pop)
        begin
            slot_reg[0] <= slot_reg[1];
        end
        if (push && wr_idx)
        begin
            slot_reg[1] <= new_item;
        end
    end

endmodule

`default_nettype wire

### design/arf_rate_ctl.sv
// fill average and trimmed phase increment sequencer
`timescale 1ns / 1ps
`default_nettype none

module arf_rate_ctl #(
    parameter int FCW = 13
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire arf_pkg::cfg_t    cfg,
    input  wire logic             cfg_we,
    input  wire logic             avg_start,
    input  wire logic [FCW-1:0]   fill_count,
    output arf_pkg::rate_out_t    rate
);
    import arf_pkg::*;

    rate_state_t        state_reg;
    rate_state_t        state_next;
    logic               redo_reg;
    logic               redo_next;
    logic [AVG_W-1:0]   avg_reg;
    logic [48:0]        prod_a_reg;
    logic [FCW+15:0]    prod_b_reg;
    logic [AVG_W-1:0]   err_reg;
    logic               err_big_reg;
    logic               below_reg;
    logic [AVG_W-1:0]   trim_reg;
    logic [PHASE_W-1:0] inc_reg;

    logic [16:0]        wc;
    logic [49:0]        avg_sum;
    logic [33:0]        avg_shift;
    logic [AVG_W-1:0]   tgt;
    logic [AVG_W-1:0]   band;
    logic [47:0]        trim_prod;
    logic [40:0]        inc_sum;

    always_comb
    begin
        state_next = state_reg;
        redo_next  = redo_reg | cfg_we;
        case (state_reg)
            RS_IDLE:
            begin
                redo_next = 1'b0;
                if (avg_start)
                begin
                    state_next = RS_AVG_MUL;
                end
                else if (cfg_we)
                begin
                    state_next = RS_ERR;
                end
            end
            RS_AVG_MUL: state_next = RS_AVG_FC;
            RS_AVG_FC:  state_next = RS_AVG_SUM;
            RS_AVG_SUM: state_next = RS_ERR;
            RS_ERR:
            begin
                redo_next  = cfg_we;
                state_next = RS_TRIM;
            end
            RS_TRIM:    state_next = RS_INC;
            RS_INC:     state_next = (redo_reg || cfg_we) ? RS_ERR : RS_IDLE;
            default:    state_next = RS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_ERR;
            redo_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            redo_reg  <= redo_next;
        end
    end

    always_comb
    begin
        wc        = 17'd65536 - {1'b0, cfg.weight};
        avg_sum   = 50'(prod_a_reg) + 50'({prod_b_reg, 16'b0}) + 50'd32768;
        avg_shift = avg_sum[49:16];
        tgt       = {3'b0, cfg.target, 16'b0};
        band      = {3'b0, cfg.deadband, 16'b0};
        trim_prod = 48'(cfg.gain) * 48'(err_reg);
        inc_sum   = 41'(cfg.base_inc) + 41'(trim_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
        end
        else if (state_reg == RS_AVG_SUM)
        begin
            avg_reg <= (avg_shift[33:32] != 2'b00) ? '1 : avg_shift[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            RS_AVG_MUL: prod_a_reg <= 49'(avg_reg) * 49'(wc);
            RS_AVG_FC:  prod_b_reg <= (FCW+16)'(fill_count) * (FCW+16)'(cfg.weight);
            RS_ERR:
            begin
                err_reg     <= (tgt > avg_reg) ? (tgt - avg_reg) : (avg_reg - tgt);
                err_big_reg <= ((tgt > avg_reg) ? (tgt - avg_reg) : (avg_reg - tgt)) > band;
                below_reg   <= (avg_reg < tgt);
            end
            RS_TRIM:    trim_reg <= err_big_reg ? trim_prod[47:16] : '0;
            RS_INC:
            begin
                if (below_reg)
                begin
                    inc_reg <= inc_sum[40] ? '1 : inc_sum[39:0];
                end
                else
                begin
                    inc_reg <= (40'(trim_reg) > cfg.base_inc) ? '0
                               : (cfg.base_inc - 40'(trim_reg));
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rate.busy      = (state_reg != RS_IDLE);
    assign rate.increment = inc_reg;

endmodule

`default_nettype wire

### design/arf_back.sv
// back part: decimator, sample fifo, block play control and result register
`timescale 1ns / 1ps
`default_nettype none

module arf_back #(
    parameter int DEPTH = 4096,
    parameter int PW    = 12,
    parameter int FCW   = 13
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire arf_pkg::q_item_t     q_item,
    output logic                      q_pop,
    input  wire logic [12:0]          block_len,
    input  wire arf_pkg::rate_out_t   rate,
    output logic                      avg_start,
    output logic [FCW-1:0]            fill_count,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [15:0]        sample_out,
    output logic                      kept,
    output logic                      overflow,
    output logic                      block_plays,
    output logic [12:0]               fill_level
);
    import arf_pkg::*;

    localparam int CW = (FCW > 13) ? FCW : 13;

    logic [SAMPLE_W-1:0] mem [DEPTH];

    logic [PW-1:0]      wp_reg, wp_next;
    logic [PW-1:0]      rp_reg, rp_next;
    logic [FCW-1:0]     fc_reg, fc_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               active_reg, active_next;
    logic [12:0]        remain_reg, remain_next;
    logic               out_valid_reg, out_valid_next;

    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                sel_reg, sel_next;
    logic                kept_reg, kept_next;
    logic                ovf_reg, ovf_next;
    logic                plays_reg;
    logic [12:0]         level_reg;

    logic               exec;
    logic               wr_en;
    logic               rd_en;
    logic [PHASE_W-1:0] ph_base;
    logic [40:0]        ph_sum;

    assign exec  = q_valid && !rate.busy && (!out_valid_reg || !out_stall);
    assign q_pop = exec;

    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        fc_next     = fc_reg;
        phase_next  = phase_reg;
        active_next = active_reg;
        remain_next = remain_reg;
        sel_next    = 1'b0;
        kept_next   = 1'b0;
        ovf_next    = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        avg_start   = 1'b0;
        ph_base     = phase_reg;
        ph_sum      = '0;
        case (q_item.op)
            OP_PUSH:
            begin
                if (phase_reg >= PHASE_ONE)
                begin
                    ph_base = phase_reg - PHASE_ONE;
                    if (fc_reg == FCW'(DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en     = exec;
                        wp_next   = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                        fc_next   = fc_reg + 1'b1;
                        kept_next = 1'b1;
                    end
                end
                ph_sum     = 41'(ph_base) + 41'(rate.increment);
                phase_next = ph_sum[40] ? '1 : ph_sum[39:0];
            end
            OP_BLOCK:
            begin
                avg_start   = exec;
                active_next = (CW'(fc_reg) >= CW'(block_len));
                remain_next = block_len;
            end
            OP_PULL:
            begin
                if (remain_reg != 13'd0)
                begin
                    remain_next = remain_reg - 1'b1;
                    if (active_reg && (fc_reg != '0))
                    begin
                        rd_en    = exec;
                        rp_next  = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
                        fc_next  = fc_reg - 1'b1;
                        sel_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            fc_reg        <= '0;
            phase_reg     <= '0;
            active_reg    <= 1'b0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (exec)
            begin
                wp_reg     <= wp_next;
                rp_reg     <= rp_next;
                fc_reg     <= fc_next;
                phase_reg  <= phase_next;
                active_reg <= active_next;
                remain_reg <= remain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= q_item.sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            sel_reg   <= sel_next;
            kept_reg  <= kept_next;
            ovf_reg   <= ovf_next;
            plays_reg <= active_next;
            level_reg <= 13'(fc_next);
        end
    end

    assign fill_count  = fc_reg;
    assign out_valid   = out_valid_reg;
    assign sample_out  = sel_reg ? rd_data_reg : '0;
    assign kept        = kept_reg;
    assign overflow    = ovf_reg;
    assign block_plays = plays_reg;
    assign fill_level  = level_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FCW'(DEPTH))
        else $error("fifo fill above depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ovf_reg |-> fc_reg == FCW'(DEPTH))
        else $error("overflow reported while fifo not full");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> fc_reg == $past(fc_reg) - 1'b1)
        else $error("pop did not lower the fill");

    a_no_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
        avg_start |=> rate.busy && !exec)
        else $error("item executed while averaging");
`endif

endmodule

`default_nettype wire

### design/adaptive_rate_audio_fifo_top.sv
// top level of the adaptive rate audio fifo: config registers and part wiring
// items queue in the front part; each result is registered by the back part
// throughput: one item per cycle unless out_stall or a busy rate control holds it; a block
// start holds the back part while the fill average and the trimmed increment are recomputed
// a config write recomputes the increment; likewise right after reset
// reset clears pointers, fill, phase, average and block state; sample memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module adaptive_rate_audio_fifo_top #(
    parameter int FIFO_DEPTH = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [39:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          action,
    input  wire logic signed [15:0]  sample_in,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [15:0]       sample_out,
    output logic                     kept,
    output logic                     overflow,
    output logic                     block_plays,
    output logic [12:0]              fill_level
);
    import arf_pkg::*;

    localparam int PW  = $clog2(FIFO_DEPTH);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);

    cfg_t           cfg_reg;
    logic           q_valid;
    logic           q_pop;
    q_item_t        q_item;
    rate_out_t      rate;
    logic           avg_start;
    logic [FCW-1:0] fill_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_inc  <= RST_BASE_INC;
            cfg_reg.target    <= RST_TARGET;
            cfg_reg.deadband  <= RST_DEADBAND;
            cfg_reg.gain      <= RST_GAIN;
            cfg_reg.weight    <= RST_WEIGHT;
            cfg_reg.block_len <= RST_BLOCK_LEN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_INC:  cfg_reg.base_inc  <= cfg_data;
                REG_TARGET:    cfg_reg.target    <= cfg_data[12:0];
                REG_DEADBAND:  cfg_reg.deadband  <= cfg_data[12:0];
                REG_GAIN:      cfg_reg.gain      <= cfg_data[15:0];
                REG_WEIGHT:    cfg_reg.weight    <= cfg_data[15:0];
                REG_BLOCK_LEN: cfg_reg.block_len <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    arf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .sample_in (sample_in),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    arf_rate_ctl #(
        .FCW (FCW)
    ) u_rate (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cfg_we     (cfg_we),
        .avg_start  (avg_start),
        .fill_count (fill_count),
        .rate       (rate)
    );

    arf_back #(
        .DEPTH (FIFO_DEPTH),
        .PW    (PW),
        .FCW   (FCW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .block_len   (cfg_reg.block_len),
        .rate        (rate),
        .avg_start   (avg_start),
        .fill_count  (fill_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .kept        (kept),
        .overflow    (overflow),
        .block_plays (block_plays),
        .fill_level  (fill_level)
    );

endmodule

`default_nettype wire
